[hw/rtl/ffpa_pkg.sv]
package ffpa_pkg;

	// Field widths
	localparam int PAGE_W   = 10;
	localparam int CNT_W    = 11;
	localparam int SUM_W    = 12;
	localparam int STATUS_W = 2;

	// heap_pages value after reset
	localparam logic [CNT_W-1:0] HEAP_RESET = 11'd1024;

	// Request opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 2'd2;

	// Per-page entry of the mark store
	typedef struct packed {
		logic start;
		logic mark;
	} mark_t;

	// Operands of the shared add/compare unit
	typedef struct packed {
		logic [CNT_W-1:0] a;
		logic [CNT_W-1:0] b;
		logic [SUM_W-1:0] c;
	} unit_op_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             ge;
	} unit_res_t;

endpackage

[hw/rtl/ffpa_if.sv]
// Request channel into the allocator
interface ffpa_req_if;
	import ffpa_pkg::*;
	logic                valid;
	logic                ready;
	logic                op;
	logic [CNT_W-1:0]    size_pages;
	logic [PAGE_W-1:0]   page_index;

	modport source (output valid, op, size_pages, page_index, input ready);
	modport sink   (input valid, op, size_pages, page_index, output ready);
endinterface

// Result channel out of the allocator
interface ffpa_rsp_if;
	import ffpa_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PAGE_W-1:0]   alloc_page;
	logic [CNT_W-1:0]    freed_count;

	modport source (output valid, status, alloc_page, freed_count, input ready);
	modport sink   (input valid, status, alloc_page, freed_count, output ready);
endinterface

[hw/rtl/ffpa_ram.sv]
module ffpa_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/ffpa_addcmp.sv]
module ffpa_addcmp (
	input  ffpa_pkg::unit_op_t  op_in,
	output ffpa_pkg::unit_res_t res
);
	import ffpa_pkg::*;

	logic [SUM_W-1:0] sum;

	// Shared adder with a greater-or-equal check on the sum
	assign sum     = SUM_W'(op_in.a) + SUM_W'(op_in.b);
	assign res.sum = sum;
	assign res.ge  = (sum >= op_in.c);

endmodule

[hw/rtl/first_fit_page_range_allocator.sv]
// Allocate: accept, a scan below top (cut short on an early fit), a top check when nothing
//   fits, marking of size_pages pages, then post.
// Free: accept, read, clear pages, then a trim read and a trim that drops pages (only
//   the read when top is 0), then post. One request at a time; the next is taken while the
//   previous result waits for ready.
// Reset: top, control and the fill mark cleared (unwritten pages read free), heap_pages 1024.
module first_fit_page_range_allocator #(
	parameter int PAGE_COUNT = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [ffpa_pkg::CNT_W-1:0]  cfg_wdata,
	ffpa_req_if.sink                    req,
	ffpa_rsp_if.source                  rsp
);
	import ffpa_pkg::*;

	localparam int AW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int CAP_I = (PAGE_COUNT < 2047) ? PAGE_COUNT : 2047;
	localparam logic [CNT_W-1:0] LIM_CAP = CNT_W'(CAP_I);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_SCAN    = 9'b000000010,
		S_CHECK   = 9'b000000100,
		S_MARK    = 9'b000001000,
		S_FREE_RD = 9'b000010000,
		S_FREE    = 9'b000100000,
		S_TRIM_RD = 9'b001000000,
		S_TRIM    = 9'b010000000,
		S_DONE    = 9'b100000000
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    heap_q;
	logic [CNT_W-1:0]    top_q;
	logic [CNT_W-1:0]    hwm_q;
	logic [CNT_W-1:0]    p_q;
	logic                pend_q;
	logic [CNT_W-1:0]    run_q;
	logic [CNT_W-1:0]    rstart_q;
	logic [CNT_W-1:0]    start_q;
	logic [CNT_W-1:0]    n_q;
	logic [PAGE_W-1:0]   first_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    rem_q;
	logic                head_q;
	logic [STATUS_W-1:0] status_q;
	logic [CNT_W-1:0]    rd_page_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [PAGE_W-1:0]   out_page_q;
	logic [CNT_W-1:0]    out_cnt_q;

	logic [CNT_W-1:0]    lim;
	logic [CNT_W-1:0]    rd_addr;
	mark_t               rdata;
	mark_t               d;
	logic                d_free;
	unit_op_t            u_op;
	unit_res_t           u_res;
	logic                we;
	mark_t               wdata;
	logic                scan_hit;
	logic                issue_ok;
	logic                free_go;

	// Effective heap limit
	assign lim = (heap_q > LIM_CAP) ? LIM_CAP : heap_q;

	// Mark store
	ffpa_ram #(
		.WIDTH($bits(mark_t)),
		.DEPTH(PAGE_COUNT)
	) u_marks (
		.clk  (clk),
		.we   (we),
		.waddr(AW'(p_q)),
		.wdata(wdata),
		.raddr(AW'(rd_addr)),
		.rdata(rdata)
	);

	// Pages at or above the fill mark were never written: they read as free
	assign d      = (rd_page_q < hwm_q) ? rdata : '0;
	assign d_free = !d.mark;

	// Read address per step
	always_comb begin
		unique case (state_q)
			S_FREE:    rd_addr = p_q + 11'd1;
			S_TRIM_RD: rd_addr = top_q - 11'd1;
			S_TRIM:    rd_addr = top_q - 11'd2;
			default:   rd_addr = p_q;
		endcase
	end

	// Shared add/compare operands
	always_comb begin
		u_op = '0;
		unique case (state_q)
			S_SCAN: begin
				u_op.a = run_q;
				u_op.b = 11'd1;
				u_op.c = SUM_W'(n_q);
			end
			S_CHECK: begin
				u_op.a = top_q;
				u_op.b = n_q;
				u_op.c = SUM_W'(lim) + 12'd1;
			end
			S_FREE: begin
				u_op.a = cnt_q;
				u_op.b = 11'd1;
			end
			default: u_op = '0;
		endcase
	end

	ffpa_addcmp u_unit (
		.op_in(u_op),
		.res  (u_res)
	);

	// Step decisions
	assign scan_hit = pend_q && d_free && u_res.ge;
	assign issue_ok = (p_q < top_q);
	assign free_go  = (p_q < lim) &&
		((p_q == CNT_W'(first_q)) || (d.mark && !d.start));

	// Store writes: mark a range, or clear one page
	assign we          = (state_q == S_MARK) || ((state_q == S_FREE) && free_go);
	assign wdata.mark  = (state_q == S_MARK);
	assign wdata.start = (state_q == S_MARK) && head_q;

	// Handshakes
	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.alloc_page  = out_page_q;
	assign rsp.freed_count = out_cnt_q;

	// Result register: loaded from the done step once it is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && (!out_valid_q || rsp.ready)) begin
			out_valid_q  <= 1'b1;
			out_status_q <= status_q;
			out_page_q   <= start_q[PAGE_W-1:0];
			out_cnt_q    <= cnt_q;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			heap_q      <= HEAP_RESET;
			top_q       <= '0;
			hwm_q       <= '0;
			pend_q      <= 1'b0;
			rd_page_q   <= '0;
		end else begin
			rd_page_q <= rd_addr;
			if (cfg_wen) begin
				heap_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						n_q      <= req.size_pages;
						first_q  <= req.page_index;
						start_q  <= '0;
						cnt_q    <= '0;
						run_q    <= '0;
						pend_q   <= 1'b0;
						if (req.op == OP_FREE) begin
							status_q <= ST_DONE;
							p_q      <= CNT_W'(req.page_index);
							state_q  <= S_FREE_RD;
						end else if (req.size_pages == '0) begin
							status_q <= ST_ZERO_SIZE;
							state_q  <= S_DONE;
						end else begin
							status_q <= ST_DONE;
							p_q      <= '0;
							state_q  <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// evaluate the page read last cycle
					if (pend_q) begin
						if (d_free) begin
							run_q <= u_res.sum[CNT_W-1:0];
							if (run_q == '0) begin
								rstart_q <= rd_page_q;
							end
						end else begin
							run_q <= '0;
						end
					end
					if (scan_hit) begin
						start_q <= (run_q == '0) ? rd_page_q : rstart_q;
						p_q     <= (run_q == '0) ? rd_page_q : rstart_q;
						rem_q   <= n_q;
						head_q  <= 1'b1;
						state_q <= S_MARK;
					end else if (issue_ok) begin
						p_q    <= p_q + 11'd1;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					// grow at top unless the limit would be passed
					if (u_res.ge) begin
						status_q <= ST_NO_ROOM;
						state_q  <= S_DONE;
					end else begin
						start_q <= top_q;
						p_q     <= top_q;
						top_q   <= u_res.sum[CNT_W-1:0];
						rem_q   <= n_q;
						head_q  <= 1'b1;
						state_q <= S_MARK;
					end
				end
				S_MARK: begin
					if (p_q == hwm_q) begin
						hwm_q <= hwm_q + 11'd1;
					end
					p_q    <= p_q + 11'd1;
					rem_q  <= rem_q - 11'd1;
					head_q <= 1'b0;
					if (rem_q == 11'd1) begin
						state_q <= S_DONE;
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE;
				end
				S_FREE: begin
					if (free_go) begin
						cnt_q <= u_res.sum[CNT_W-1:0];
						p_q   <= p_q + 11'd1;
					end else begin
						state_q <= S_TRIM_RD;
					end
				end
				S_TRIM_RD: begin
					state_q <= (top_q == '0) ? S_DONE : S_TRIM;
				end
				S_TRIM: begin
					// lower top over free pages directly below it
					if ((top_q != '0) && d_free) begin
						top_q <= top_q - 11'd1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Between requests top never lies above the fill mark
	a_top_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (top_q <= hwm_q))
		else $error("top above fill mark while idle");

	// The store is written only while marking or clearing
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> ((state_q == S_MARK) || (state_q == S_FREE)))
		else $error("mark store written outside mark/free");

	// A failed allocate reports no page and no count
	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ST_DONE)) |->
			((rsp.alloc_page == '0) && (rsp.freed_count == '0)))
		else $error("failed request carries page or count");

	// In the cycle after a request is taken the block is busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while previous one in flight");

endmodule

[tb/page_range_checker.sv]
// Watches the request, result and register ports, predicts every result
// and compares it with what the allocator returns.
module page_range_checker #(
	parameter int PAGE_COUNT = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [ffpa_pkg::CNT_W-1:0] cfg_wdata,
	ffpa_req_if                        req,
	ffpa_rsp_if                        rsp,
	output int                         errors,
	output int                         owed
);
	import ffpa_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PAGE_W-1:0]   alloc_page;
		logic [CNT_W-1:0]    freed_count;
	} page_rsp_t;

	// Shadow of the allocator state
	mark_t            page_mark [PAGE_COUNT];
	logic [CNT_W-1:0] top_page;
	logic [CNT_W-1:0] heap_pages;

	// Results owed by the allocator, oldest first
	page_rsp_t rsp_due_q[$];

	// Apply one request to the shadow state and return its result
	function automatic page_rsp_t run_request(logic op, logic [CNT_W-1:0] size,
		logic [PAGE_W-1:0] page);
		page_rsp_t r;
		int lim, n, top_n, scan_end, run, run_start, start, p, count;
		bit run_ok;
		r = '0;
		lim = (heap_pages < PAGE_COUNT) ? int'(heap_pages) : PAGE_COUNT;
		n = size;
		top_n = top_page;
		if (op == OP_ALLOC) begin
			if (n == 0) begin
				r.status = ST_ZERO_SIZE;
				return r;
			end
			// first fit below top
			scan_end = (top_n < PAGE_COUNT) ? top_n : PAGE_COUNT;
			run = 0;
			run_start = 0;
			run_ok = 1'b0;
			for (int i = 0; run < n && i < scan_end; i++) begin
				if (!page_mark[i].mark) begin
					if (run == 0) begin
						run_start = i;
						run_ok = 1'b1;
					end
					run++;
				end else begin
					run = 0;
					run_ok = 1'b0;
				end
			end
			if (run_ok && run >= n) begin
				start = run_start;
			end else if (top_n + n > lim) begin
				r.status = ST_NO_ROOM;
				return r;
			end else begin
				// grow the heap at top
				start = top_n;
				top_page = CNT_W'(top_n + n);
			end
			for (int i = 0; i < n; i++) begin
				p = start + i;
				if (p < PAGE_COUNT)
					page_mark[p] = '{start: (i == 0), mark: 1'b1};
			end
			r.status = ST_DONE;
			r.alloc_page = PAGE_W'(start);
		end else begin
			// named page goes if below the limit, then marked non-start pages after it
			p = page;
			count = 0;
			while (p < lim && (p == page || (!page_mark[p].start && page_mark[p].mark))) begin
				page_mark[p] = '0;
				p++;
				count++;
			end
			// pull top down over trailing free pages
			top_n = top_page;
			while (top_n > 0 && top_n <= PAGE_COUNT && !page_mark[top_n-1].mark)
				top_n--;
			top_page = CNT_W'(top_n);
			r.status = ST_DONE;
			r.freed_count = CNT_W'(count);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		page_rsp_t want;
		if (!arst_n) begin
			foreach (page_mark[i])
				page_mark[i] = '0;
			top_page = '0;
			heap_pages = HEAP_RESET;
			rsp_due_q.delete();
			errors = 0;
			owed = 0;
		end else begin
			// compare the result first; a new request cannot answer this edge
			if (rsp.valid && rsp.ready) begin
				if (rsp_due_q.size() == 0) begin
					errors++;
					$error("result with no request outstanding");
				end else begin
					want = rsp_due_q.pop_front();
					if (rsp.status !== want.status) begin
						errors++;
						$error("status: expected %0d, got %0d", want.status, rsp.status);
					end
					if (rsp.alloc_page !== want.alloc_page) begin
						errors++;
						$error("alloc_page: expected %0d, got %0d", want.alloc_page,
							rsp.alloc_page);
					end
					if (rsp.freed_count !== want.freed_count) begin
						errors++;
						$error("freed_count: expected %0d, got %0d", want.freed_count,
							rsp.freed_count);
					end
				end
			end
			if (cfg_wen)
				heap_pages = cfg_wdata;
			if (req.valid && req.ready)
				rsp_due_q.push_back(run_request(req.op, req.size_pages, req.page_index));
			owed = rsp_due_q.size();
		end
	end

endmodule

[tb/tb_first_fit_page_range_allocator.sv]
// Stimulus and verdict for the page range allocator; checking is in page_range_checker.
module tb_first_fit_page_range_allocator;
	import ffpa_pkg::*;

	localparam int PAGE_COUNT  = 1024;
	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int N_PHASES    = 7;
	localparam int PHASE_ITEMS = 78;

	logic             clk;
	logic             arst_n;
	logic             cfg_wen;
	logic [CNT_W-1:0] cfg_wdata;

	ffpa_req_if req();
	ffpa_rsp_if rsp();

	int errors;
	int owed;
	int idle_pct;
	int stall_pct;
	int hold_ask = 0;
	int quiet_cycles = 0;

	// ops in flight and start pages handed out, used to aim frees
	logic              sent_op_q[$];
	logic [PAGE_W-1:0] live_q[$];

	// heap size, sender idle and receiver stall per random phase
	int ph_heap  [N_PHASES] = '{64, 32, 128, 48, 1024, 1, 16};
	int ph_idle  [N_PHASES] = '{0, 55, 0, 15, 0, 55, 15};
	int ph_stall [N_PHASES] = '{0, 0, 55, 15, 55, 0, 15};

	first_fit_page_range_allocator #(
		.PAGE_COUNT(PAGE_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.rsp(rsp)
	);

	page_range_checker #(
		.PAGE_COUNT(PAGE_COUNT)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.rsp(rsp),
		.errors(errors),
		.owed(owed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result side: random stalls plus one long hold-off on request
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_ask != hold_seen) begin
				hold_left = HOLD_CYCLES;
				hold_seen = hold_ask;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Track live ranges and watch for a hang
	always @(posedge clk) begin
		logic op;
		if (rsp.valid && rsp.ready && sent_op_q.size() > 0) begin
			op = sent_op_q.pop_front();
			if (op == OP_ALLOC && rsp.status == ST_DONE)
				live_q.push_back(rsp.alloc_page);
		end
		if (req.valid && req.ready)
			sent_op_q.push_back(req.op);
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_first_fit_page_range_allocator: FAIL");
			$finish;
		end
	end

	// Offer one request, with random idle cycles ahead of it; returns after acceptance
	task automatic send_req(logic op, int sz, int pg);
		if ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.size_pages <= CNT_W'(sz);
		req.page_index <= PAGE_W'(pg);
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	// Stop sending and wait for every owed result
	task automatic drain_results();
		req.valid <= 1'b0;
		do @(negedge clk); while (owed != 0);
	endtask

	// Heap size is changed only with the allocator idle
	task automatic set_heap(int pages);
		drain_results();
		cfg_wen <= 1'b1;
		cfg_wdata <= CNT_W'(pages);
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	initial begin
		int lim, cap, sz, pg, k;
		logic op;
		req.valid = 1'b0;
		req.op = OP_ALLOC;
		req.size_pages = '0;
		req.page_index = '0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: heap at its reset size
		send_req(OP_ALLOC, 0, 1023);     // zero size
		send_req(OP_ALLOC, 1, 0);        // page 0
		send_req(OP_ALLOC, 3, 0);        // pages 1..3
		send_req(OP_ALLOC, 2, 0);        // pages 4..5
		send_req(OP_FREE, 1024, 1);      // stops at the start of 4
		send_req(OP_ALLOC, 2, 0);        // first fit at 1..2
		send_req(OP_ALLOC, 2, 0);        // hole at 3 too short, goes to top
		send_req(OP_FREE, 0, 3);         // named page already free
		send_req(OP_FREE, 0, 5);         // middle of a range
		send_req(OP_ALLOC, 1024, 0);     // no room above top
		send_req(OP_FREE, 0, 0);
		send_req(OP_FREE, 0, 1);
		send_req(OP_FREE, 0, 4);
		send_req(OP_FREE, 0, 6);         // top falls back to zero
		send_req(OP_ALLOC, 1024, 0);     // whole heap
		send_req(OP_FREE, 0, 0);         // clears all of it

		// zero limit
		set_heap(0);
		send_req(OP_ALLOC, 1, 0);
		send_req(OP_FREE, 0, 5);
		// one page
		set_heap(1);
		send_req(OP_ALLOC, 1, 0);
		send_req(OP_FREE, 0, 0);
		// limit lowered below top
		set_heap(8);
		send_req(OP_ALLOC, 6, 0);
		set_heap(3);
		send_req(OP_ALLOC, 1, 0);        // top blocked by the limit
		send_req(OP_FREE, 0, 4);         // beyond the limit
		send_req(OP_FREE, 0, 0);         // clear stops at the limit
		send_req(OP_ALLOC, 2, 0);        // search below top still works
		set_heap(1024);
		send_req(OP_FREE, 0, 0);
		send_req(OP_FREE, 0, 3);

		// Random phases
		for (int ph = 0; ph < N_PHASES; ph++) begin
			set_heap(ph_heap[ph]);
			idle_pct = ph_idle[ph];
			stall_pct = ph_stall[ph];
			lim = ph_heap[ph];
			cap = (lim < 8) ? lim : 8;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// long hold-off on the result side while requests keep coming
				if (ph == 0 && i == 20)
					hold_ask++;
				// let the allocator run dry once mid-phase
				if (ph == 3 && i == 40)
					drain_results();
				if ($urandom_range(99) < 55) begin
					op = OP_ALLOC;
					k = $urandom_range(99);
					if (k < 4)
						sz = 0;
					else if (k < 8)
						sz = $urandom_range(1, lim);
					else if (k < 10)
						sz = $urandom_range(0, 1024);
					else
						sz = $urandom_range(1, cap);
					pg = $urandom_range(0, 1023);
				end else begin
					op = OP_FREE;
					sz = $urandom_range(0, 1024);
					if (live_q.size() > 0 && $urandom_range(99) < 80) begin
						k = $urandom_range(0, live_q.size() - 1);
						pg = live_q[k];
						live_q.delete(k);
					end else if ($urandom_range(99) < 50) begin
						pg = $urandom_range(0, (lim < PAGE_COUNT) ? lim - 1 : PAGE_COUNT - 1);
					end else begin
						pg = $urandom_range(0, 1023);
					end
				end
				send_req(op, sz, pg);
			end
		end

		drain_results();
		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("tb_first_fit_page_range_allocator: PASS");
		else
			$display("tb_first_fit_page_range_allocator: FAIL");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/ffpa_pkg.sv
hw/rtl/ffpa_if.sv
hw/rtl/ffpa_ram.sv
hw/rtl/ffpa_addcmp.sv
hw/rtl/first_fit_page_range_allocator.sv
tb/page_range_checker.sv
tb/tb_first_fit_page_range_allocator.sv
